// ===== rtl/lhb_pkg.sv =====
// Shared constants and types for the lower hull baseline block.
package lhb_pkg;
  localparam int MaxSamples = 1024;
  localparam int XBits      = 32;
  localparam int YBits      = 24;
  localparam int IdxBits    = $clog2(MaxSamples);
  localparam int CntBits    = IdxBits + 1;
  localparam int PrdBits    = XBits + YBits + 2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatXOrder  = 2'd1;
  localparam logic [1:0] StatFull    = 2'd2;
  localparam logic [1:0] StatBadRead = 2'd3;

  typedef enum logic [4:0] {
    CmdNone,
    CmdLoadRd,     // read previous x
    CmdLoadChk,    // write sample, check order
    CmdHullRd,     // read top two hull entries
    CmdHullXy,     // read x/y of hull points
    CmdHullXy2,
    CmdHullMul,    // form cross products
    CmdHullCmp,    // pop or push
    CmdSegRd,      // read hull[s], hull[s+1]
    CmdSegXy,      // read endpoints
    CmdSegXy2,
    CmdSegSet,     // latch segment
    CmdPtRd,       // read sample j
    CmdPtMul,      // numerator multiply
    CmdDivStart,
    CmdDivStep,
    CmdPtWr,       // write baseline
    CmdLastRd,
    CmdLastWr,
    CmdReadRd,
    CmdReadOut
  } cmd_e;

  typedef struct packed {
    logic          prev_ok;     // x increasing
    logic          full;
    logic          cnt_zero;
    logic          hull_gt1;
    logic          left;        // new point strictly left
    logic          seg_more;    // s+1 < hull_count
    logic          pt_more;     // j < b
    logic          div_done;
    logic          ready;
    logic          read_ok;
  } stat_t;
endpackage

// ===== rtl/lower_hull_baseline_top.sv =====
// Top level of the lower hull baseline block.
// Throughput: one word at a time; busy stays high through the result strobe.
// The last load adds a baseline pass over the samples (bit-serial divider).
// Reset clears counts and ready flag; stores are undefined until written.
// Results appear for one cycle on done_o; the receiver cannot stall.
module lower_hull_baseline_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic        operation_i,
  input  logic [31:0] sample_x_i,
  input  logic [23:0] sample_y_i,
  input  logic        last_sample_i,
  input  logic [9:0]  read_index_i,
  output logic [23:0] baseline_o,
  output logic [1:0]  status_o
);
  import lhb_pkg::*;

  cmd_e  cmd;
  stat_t stat;
  logic  clear;
  logic [23:0] bl;

  lhb_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .op_i(operation_i), .last_i(last_sample_i),
    .stat_i(stat), .cmd_o(cmd), .clear_o(clear), .busy_o(busy), .done_o,
    .status_o);

  lhb_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .clear_i(clear), .x_i(sample_x_i[XBits-1:0]),
    .y_i(sample_y_i[YBits-1:0]), .read_index_i, .stat_o(stat), .baseline_o(bl));

  assign baseline_o = bl;
endmodule

// ===== rtl/lhb_ram.sv =====
// Generic single port RAM with registered read.
module lhb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== rtl/lhb_datapath.sv =====
// Datapath: sample, hull and baseline stores, cross product and divider.
module lhb_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lhb_pkg::cmd_e           cmd_i,
  input  logic                    clear_i,
  input  logic [lhb_pkg::XBits-1:0] x_i,
  input  logic [lhb_pkg::YBits-1:0] y_i,
  input  logic [9:0]              read_index_i,
  output lhb_pkg::stat_t          stat_o,
  output logic [23:0]             baseline_o
);
  import lhb_pkg::*;

  localparam int DivBits = XBits + YBits;
  localparam int StepBits = $clog2(DivBits + 1);

  logic [CntBits-1:0] scnt_q, hcnt_q, seg_q, j_q, b_q;
  logic               ready_q;
  logic [XBits-1:0]   xa_q, xb_q, xc_q, xn_q;
  logic [YBits-1:0]   ya_q, yb_q, yc_q, yn_q;
  logic [9:0]         rd_idx_q;
  logic               down_q;
  logic [YBits-1:0]   dy_q;
  logic [XBits-1:0]   den_q;
  logic signed [PrdBits-1:0] p1_q, p2_q;
  logic [DivBits-1:0] num_q, quo_q;
  logic [XBits:0]     rem_q;
  logic [StepBits-1:0] step_q;
  logic [23:0]        out_q;

  logic               xwe, ywe, hwe, bwe;
  logic [IdxBits-1:0] xaddr, haddr, baddr;
  logic [XBits-1:0]   xrd;
  logic [YBits-1:0]   yrd, brd, bwd;
  logic [IdxBits-1:0] hrd;
  logic [IdxBits-1:0] hwd;

  lhb_ram #(.Width(XBits), .Depth(MaxSamples)) u_x (
    .clk_i, .we_i(xwe), .addr_i(xaddr), .wdata_i(xn_q), .rdata_o(xrd));
  lhb_ram #(.Width(YBits), .Depth(MaxSamples)) u_y (
    .clk_i, .we_i(ywe), .addr_i(xaddr), .wdata_i(yn_q), .rdata_o(yrd));
  lhb_ram #(.Width(IdxBits), .Depth(MaxSamples)) u_h (
    .clk_i, .we_i(hwe), .addr_i(haddr), .wdata_i(hwd), .rdata_o(hrd));
  lhb_ram #(.Width(YBits), .Depth(MaxSamples)) u_b (
    .clk_i, .we_i(bwe), .addr_i(baddr), .wdata_i(bwd), .rdata_o(brd));

  logic [CntBits-1:0] scnt_eff, hcnt_eff;
  assign scnt_eff = clear_i ? '0 : scnt_q;
  assign hcnt_eff = clear_i ? '0 : hcnt_q;

  // hull and segment reads take two steps; the x/y reads follow in the next cycle
  logic hsel_q;

  always_comb begin
    xwe = 1'b0; ywe = 1'b0; hwe = 1'b0; bwe = 1'b0;
    xaddr = '0; haddr = '0; baddr = '0;
    hwd = scnt_q[IdxBits-1:0] - 1'b1;
    bwd = '0;
    case (cmd_i)
      CmdLoadRd: xaddr = scnt_eff[IdxBits-1:0] - 1'b1;
      CmdLoadChk: begin
        xaddr = scnt_q[IdxBits-1:0];
        xwe = stat_o.prev_ok && !stat_o.full;
        ywe = xwe;
      end
      CmdHullRd: begin
        haddr = hsel_q ? hcnt_q[IdxBits-1:0] - 1'b1
                       : hcnt_q[IdxBits-1:0] - 2'd2;
        if (hsel_q) xaddr = hrd;
      end
      CmdHullXy: xaddr = hrd;
      CmdHullCmp: begin
        haddr = hcnt_q[IdxBits-1:0];
        hwe = stat_o.left || !stat_o.hull_gt1;
      end
      CmdSegRd: begin
        haddr = hsel_q ? seg_q[IdxBits-1:0] + 1'b1 : seg_q[IdxBits-1:0];
        if (hsel_q) xaddr = hrd;
      end
      CmdSegXy: xaddr = hrd;
      CmdSegXy2: xaddr = b_q[IdxBits-1:0];
      CmdPtRd: xaddr = j_q[IdxBits-1:0];
      CmdPtWr: begin
        baddr = j_q[IdxBits-1:0];
        bwe = 1'b1;
        bwd = down_q ? ya_q - quo_q[YBits-1:0] - YBits'(rem_q != '0)
                     : ya_q + quo_q[YBits-1:0];
      end
      CmdLastRd: xaddr = scnt_q[IdxBits-1:0] - 1'b1;
      CmdLastWr: begin
        baddr = scnt_q[IdxBits-1:0] - 1'b1;
        bwe = 1'b1;
        bwd = yrd;
      end
      CmdReadRd: baddr = read_index_i[IdxBits-1:0];
      default: ;
    endcase
  end

  logic signed [XBits+1:0] dxab, dxac;
  logic signed [YBits+1:0] dyac, dyab;
  assign dxab = $signed({2'b0, xb_q}) - $signed({2'b0, xa_q});
  assign dxac = $signed({2'b0, xc_q}) - $signed({2'b0, xa_q});
  assign dyac = $signed({2'b0, yc_q}) - $signed({2'b0, ya_q});
  assign dyab = $signed({2'b0, yb_q}) - $signed({2'b0, ya_q});

  logic [XBits:0] rem_sh;
  assign rem_sh = {rem_q[XBits-1:0], num_q[DivBits-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q <= '0; hcnt_q <= '0; ready_q <= 1'b0;
      hsel_q <= 1'b0; seg_q <= '0; j_q <= '0; b_q <= '0;
      step_q <= '0; out_q <= '0;
    end else begin
      if (clear_i) begin
        scnt_q <= '0; hcnt_q <= '0; ready_q <= 1'b0;
      end
      case (cmd_i)
        CmdLoadRd: begin
          hsel_q <= 1'b0;
          xn_q <= x_i; yn_q <= y_i;
          out_q <= '0;
        end
        CmdLoadChk: begin
          xc_q <= xn_q; yc_q <= yn_q;
          if (stat_o.prev_ok && !stat_o.full) scnt_q <= scnt_q + 1'b1;
        end
        CmdHullRd: hsel_q <= ~hsel_q;
        CmdHullXy: begin
          xa_q <= xrd; ya_q <= yrd;
        end
        CmdHullXy2: begin
          xb_q <= xrd; yb_q <= yrd;
        end
        CmdHullMul: begin
          p1_q <= PrdBits'(dxab * dyac);
          p2_q <= PrdBits'(dxac * dyab);
        end
        CmdHullCmp: begin
          if (stat_o.left || !stat_o.hull_gt1) hcnt_q <= hcnt_q + 1'b1;
          else hcnt_q <= hcnt_q - 1'b1;
          hsel_q <= 1'b0;
        end
        CmdSegRd: begin
          if (hsel_q) j_q <= CntBits'(hrd);
          hsel_q <= ~hsel_q;
        end
        CmdSegXy: begin
          b_q <= CntBits'(hrd);
          xa_q <= xrd; ya_q <= yrd;
        end
        CmdSegSet: begin
          xb_q <= xrd;
          den_q <= xrd - xa_q;
          down_q <= yrd < ya_q;
          dy_q <= (yrd < ya_q) ? ya_q - yrd : yrd - ya_q;
          seg_q <= seg_q + 1'b1;
        end
        CmdPtMul: num_q <= DivBits'(dy_q * (xrd - xa_q));
        CmdDivStart: begin
          rem_q <= '0; quo_q <= '0; step_q <= StepBits'(DivBits);
        end
        CmdDivStep: begin
          num_q <= num_q << 1;
          step_q <= step_q - 1'b1;
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= rem_sh - {1'b0, den_q};
            quo_q <= {quo_q[DivBits-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[DivBits-2:0], 1'b0};
          end
        end
        CmdPtWr: j_q <= j_q + 1'b1;
        CmdLastWr: begin
          ready_q <= 1'b1; seg_q <= '0;
        end
        CmdReadRd: rd_idx_q <= read_index_i;
        CmdReadOut: out_q <= stat_o.read_ok ? 24'(brd) : '0;
        default: ;
      endcase
      if (cmd_i == CmdLoadRd) seg_q <= '0;
    end
  end

  always_comb begin
    stat_o.cnt_zero = (scnt_q == '0);
    stat_o.full     = (scnt_q >= CntBits'(MaxSamples));
    stat_o.prev_ok  = (scnt_q == '0) || (xn_q > xrd);
    stat_o.hull_gt1 = (hcnt_q > CntBits'(1));
    stat_o.left     = p1_q > p2_q;
    stat_o.seg_more = (seg_q + 1'b1) < hcnt_q;
    stat_o.pt_more  = j_q < b_q;
    stat_o.div_done = (step_q == '0);
    stat_o.ready    = ready_q;
    stat_o.read_ok  = ready_q && (CntBits'(rd_idx_q) < scnt_q);
  end
  assign baseline_o = out_q;
endmodule

// ===== rtl/lhb_ctrl.sv =====
// Controller state machine sequencing loads, hull pops, baseline pass and reads.
module lhb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           op_i,
  input  logic           last_i,
  input  lhb_pkg::stat_t stat_i,
  output lhb_pkg::cmd_e  cmd_o,
  output logic           clear_o,
  output logic           busy_o,
  output logic           done_o,
  output logic [1:0]     status_o
);
  import lhb_pkg::*;

  localparam logic [4:0] SIdle = 5'd0, SLoadChk = 5'd1, SHullRd = 5'd2,
    SHullRd2 = 5'd3, SHullXy = 5'd4, SHullXy2 = 5'd5, SHullMul = 5'd6,
    SHullCmp = 5'd7, SFinChk = 5'd8, SSegRd = 5'd9, SSegRd2 = 5'd10,
    SSegXy = 5'd11, SSegXy2 = 5'd12, SSegSet = 5'd13, SPtRd = 5'd14,
    SPtMul = 5'd15, SDivSt = 5'd16, SDiv = 5'd17, SPtWr = 5'd18,
    SLastRd = 5'd19, SLastWr = 5'd20, SDone = 5'd21, SReadOut = 5'd22,
    SHullRdA = 5'd23;

  logic [4:0] st_q, st_d;
  logic       last_q, last_d;
  logic [1:0] stat_q, stat_d;
  logic       xy_q, xy_d;

  always_comb begin
    st_d = st_q; last_d = last_q; stat_d = stat_q; xy_d = xy_q;
    cmd_o = CmdNone; clear_o = 1'b0;
    case (st_q)
      SIdle: if (start_i) begin
        if (!op_i) begin
          clear_o = stat_i.ready;
          cmd_o = CmdLoadRd; last_d = last_i; st_d = SLoadChk;
        end else begin
          cmd_o = CmdReadRd; st_d = SReadOut;
        end
      end
      SLoadChk: begin
        cmd_o = CmdLoadChk;
        if (stat_i.full) begin
          stat_d = StatFull; st_d = SFinChk;
        end else if (!stat_i.prev_ok) begin
          stat_d = StatXOrder; st_d = SFinChk;
        end else begin
          stat_d = StatOk; st_d = SHullRd;
        end
      end
      SHullRd: begin
        if (!stat_i.hull_gt1) begin
          cmd_o = CmdHullCmp; st_d = SFinChk;
        end else begin
          cmd_o = CmdHullRd; st_d = SHullRd2;
        end
      end
      SHullRd2: begin cmd_o = CmdHullRd; st_d = SHullXy; end
      SHullXy: begin cmd_o = CmdHullXy; st_d = SHullXy2; end
      SHullXy2: begin cmd_o = CmdHullXy2; st_d = SHullRdA; end
      SHullRdA: begin cmd_o = CmdHullMul; st_d = SHullCmp; end
      SHullMul: st_d = SHullCmp;
      SHullCmp: begin
        cmd_o = CmdHullCmp;
        st_d = stat_i.left ? SFinChk : SHullRd;
      end
      SFinChk: st_d = (last_q && !stat_i.cnt_zero) ? SSegRd : SDone;
      SSegRd: if (stat_i.seg_more) begin
        cmd_o = CmdSegRd; st_d = SSegRd2;
      end else begin
        st_d = SLastRd;
      end
      SSegRd2: begin cmd_o = CmdSegRd; st_d = SSegXy; end
      SSegXy: begin cmd_o = CmdSegXy; st_d = SSegXy2; end
      SSegXy2: begin cmd_o = CmdSegXy2; st_d = SSegSet; end
      SSegSet: begin cmd_o = CmdSegSet; st_d = SPtRd; end
      SPtRd: if (stat_i.pt_more) begin
        cmd_o = CmdPtRd; st_d = SPtMul;
      end else begin
        st_d = SSegRd;
      end
      SPtMul: begin cmd_o = CmdPtMul; st_d = SDivSt; end
      SDivSt: begin cmd_o = CmdDivStart; st_d = SDiv; end
      SDiv: if (stat_i.div_done) begin
        st_d = SPtWr;
      end else begin
        cmd_o = CmdDivStep;
      end
      SPtWr: begin cmd_o = CmdPtWr; st_d = SPtRd; end
      SLastRd: begin cmd_o = CmdLastRd; st_d = SLastWr; end
      SLastWr: begin cmd_o = CmdLastWr; st_d = SDone; end
      SReadOut: begin
        cmd_o = CmdReadOut;
        stat_d = stat_i.read_ok ? StatOk : StatBadRead;
        st_d = SDone;
      end
      SDone: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; last_q <= 1'b0; stat_q <= StatOk; xy_q <= 1'b0;
    end else begin
      st_q <= st_d; last_q <= last_d; stat_q <= stat_d; xy_q <= xy_d;
    end
  end

  assign busy_o   = (st_q != SIdle);
  assign done_o   = (st_q == SDone) && !xy_q;
  assign status_o = stat_q;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done while idle");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted word not held");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("no return to idle");
endmodule

// ===== tb/lower_hull_baseline_top_tb.sv =====
// Testbench for the lower hull baseline block: random spectra, reads and a shadow hull model.
`timescale 1ns / 100ps

module lower_hull_baseline_top_tb;
  import lhb_pkg::*;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;
  localparam int   StallLimit = 400000;

  typedef struct {
    logic        op;
    logic [31:0] x;
    logic [23:0] y;
    logic        last;
    logic [9:0]  idx;
    int          idle_pct;
    bit          drain;      // hold until every expected word has come back
  } word_t;

  typedef struct {
    logic [23:0] baseline;
    logic [1:0]  status;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        operation_i = 1'b0;
  logic [31:0] sample_x_i = '0;
  logic [23:0] sample_y_i = '0;
  logic        last_sample_i = 1'b0;
  logic [9:0]  read_index_i = '0;
  logic        busy, done_o;
  logic [23:0] baseline_o;
  logic [1:0]  status_o;

  lower_hull_baseline_top uut (
    .clk_i, .rst_ni, .start, .busy, .done_o, .operation_i, .sample_x_i, .sample_y_i,
    .last_sample_i, .read_index_i, .baseline_o, .status_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  word_t   pending[$];
  answer_t answers[$];
  word_t   cur;
  int      errors = 0;
  int      n_loads = 0, n_reads = 0, n_spectra = 0;
  int      stat_seen[4] = '{0, 0, 0, 0};

  // shadow state of the block
  logic [31:0] sh_x[MaxSamples];
  logic [23:0] sh_y[MaxSamples];
  int          sh_hull[MaxSamples];
  logic [23:0] sh_base[MaxSamples];
  int          sh_hcnt = 0, sh_cnt = 0;
  bit          sh_ready = 0;

  function automatic bit left_of_edge(int a, int b, int c);
    longint dxab, dyac, dxac, dyab;
    dxab = longint'({32'd0, sh_x[b]}) - longint'({32'd0, sh_x[a]});
    dxac = longint'({32'd0, sh_x[c]}) - longint'({32'd0, sh_x[a]});
    dyac = longint'({40'd0, sh_y[c]}) - longint'({40'd0, sh_y[a]});
    dyab = longint'({40'd0, sh_y[b]}) - longint'({40'd0, sh_y[a]});
    return dxab * dyac > dxac * dyab;
  endfunction

  function automatic void fit_baseline();
    int a, b;
    logic [63:0] den, dy, num, q;
    logic [31:0] v;
    bit down;
    for (int s = 0; s + 1 < sh_hcnt; s++) begin
      a = sh_hull[s];
      b = sh_hull[s + 1];
      den = {32'd0, sh_x[b] - sh_x[a]};
      down = sh_y[b] < sh_y[a];
      dy = down ? {40'd0, sh_y[a] - sh_y[b]} : {40'd0, sh_y[b] - sh_y[a]};
      for (int j = a; j < b; j++) begin
        num = dy * {32'd0, sh_x[j] - sh_x[a]};
        q = num / den;
        if (down) begin
          if (num % den != 0) q = q + 1;
          v = {8'd0, sh_y[a]} - q[31:0];
        end else begin
          v = {8'd0, sh_y[a]} + q[31:0];
        end
        sh_base[j] = v[23:0];
      end
    end
    sh_base[sh_cnt - 1] = sh_y[sh_cnt - 1];
    sh_ready = 1;
  endfunction

  function automatic void predict_answer(word_t w);
    answer_t r;
    int k;
    r.baseline = '0;
    r.status = StatOk;
    if (w.op == OpLoad) begin
      n_loads++;
      if (sh_ready) begin
        sh_cnt = 0;
        sh_hcnt = 0;
        sh_ready = 0;
      end
      if (sh_cnt >= MaxSamples) begin
        r.status = StatFull;
      end else if (sh_cnt > 0 && w.x <= sh_x[sh_cnt - 1]) begin
        r.status = StatXOrder;
      end else begin
        k = sh_cnt;
        sh_x[k] = w.x;
        sh_y[k] = w.y;
        sh_cnt++;
        while (sh_hcnt > 1 && !left_of_edge(sh_hull[sh_hcnt - 2], sh_hull[sh_hcnt - 1], k))
          sh_hcnt--;
        sh_hull[sh_hcnt] = k;
        sh_hcnt++;
      end
      if (w.last && sh_cnt > 0) begin
        fit_baseline();
        n_spectra++;
      end
    end else begin
      n_reads++;
      if (!sh_ready || int'(w.idx) >= sh_cnt) r.status = StatBadRead;
      else r.baseline = sh_base[w.idx];
    end
    stat_seen[r.status]++;
    answers.push_back(r);
  endfunction

  // driver: retire the accepted word, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_answer(cur);
      if (!start || !busy) begin
        if (pending.size() > 0 && (!pending[0].drain || answers.size() == 0) &&
            !(start && !busy && pending[0].drain) &&
            $urandom_range(99) >= pending[0].idle_pct) begin
          cur = pending.pop_front();
          operation_i   <= cur.op;
          sample_x_i    <= cur.x;
          sample_y_i    <= cur.y;
          last_sample_i <= cur.last;
          read_index_i  <= cur.idx;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && done_o) begin
      if (answers.size() == 0) begin
        $display("%0t: unexpected word baseline=%h status=%0d", $time, baseline_o, status_o);
        errors++;
      end else begin
        e = answers.pop_front();
        if (baseline_o !== e.baseline || status_o !== e.status) begin
          $display("%0t: mismatch expected baseline=%h status=%0d, actual baseline=%h status=%0d",
                   $time, e.baseline, e.status, baseline_o, status_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  int idle_now = 0;

  task automatic push_word(logic op, logic [31:0] x, logic [23:0] y, logic last,
                           logic [9:0] idx, bit drain = 0);
    word_t w;
    w.op = op; w.x = x; w.y = y; w.last = last; w.idx = idx;
    w.idle_pct = idle_now;
    w.drain = drain;
    pending.push_back(w);
  endtask

  // spectrum of n samples, occasionally out of order, then reads
  task automatic add_spectrum(int n, logic [31:0] x0, int max_step, int n_rd);
    logic [31:0] x;
    logic [23:0] y;
    int shape;
    x = x0;
    shape = $urandom_range(2);
    y = 24'($urandom);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(19) == 0)
        push_word(OpLoad, x - $urandom_range(1), 24'($urandom),
                  (i == n - 1) && ($urandom_range(1) == 1), '0);
      if (shape == 0) y = 24'($urandom);
      else if (shape == 1) y = 24'(y + $urandom_range(4095) - 2048);
      else y = 24'(32'hFFFFFF - (i * (n - i) * 37));
      push_word(OpLoad, x, y, i == n - 1, '0);
      x = x + $urandom_range(max_step, 1);
    end
    for (int i = 0; i < n_rd; i++)
      push_word(OpRead, $urandom, 24'($urandom), 1'($urandom_range(1)),
                ($urandom_range(15) == 0) ? 10'($urandom) : 10'($urandom_range(n + 2)));
  endtask

  initial begin
    int n;
    // directed: read before ready, single sample, extremes, ordering
    push_word(OpRead, '0, '0, 1'b0, 10'd0);
    push_word(OpLoad, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, '0);
    push_word(OpRead, '0, '0, 1'b0, 10'd0);
    push_word(OpRead, '0, '0, 1'b0, 10'd1);
    push_word(OpLoad, 32'd0, 24'd0, 1'b0, '0);
    push_word(OpLoad, 32'd0, 24'd5, 1'b0, '0);
    push_word(OpLoad, 32'hFFFFFFFF, 24'hFFFFFF, 1'b0, '0);
    push_word(OpLoad, 32'h80000000, 24'h123456, 1'b1, '0);
    push_word(OpRead, '0, '0, 1'b0, 10'd0);
    push_word(OpRead, '0, '0, 1'b0, 10'd1);
    push_word(OpRead, '0, '0, 1'b0, 10'd1023);
    push_word(OpLoad, 32'h10, 24'hFFFFFF, 1'b0, '0);
    push_word(OpLoad, 32'h20, 24'h0, 1'b0, '0);
    push_word(OpLoad, 32'h30, 24'hFFFFFF, 1'b0, '0);
    push_word(OpLoad, 32'h40, 24'h0, 1'b0, '0);
    push_word(OpLoad, 32'h50, 24'h800000, 1'b1, '0);
    for (int i = 0; i < 5; i++) push_word(OpRead, '0, '0, 1'b0, 10'(i));

    // fill the store completely, then overflow it
    add_spectrum(1024, $urandom_range(1000), 4000000, 0);
    pending[pending.size() - 1].last = 1'b0;
    pending[pending.size() - 2].last = 1'b0;
    push_word(OpLoad, 32'hFFFFFFFF, 24'd7, 1'b0, '0);
    push_word(OpLoad, 32'hFFFFFFFF, 24'd9, 1'b1, '0);
    for (int i = 0; i < 12; i++) push_word(OpRead, '0, '0, 1'b0, 10'($urandom_range(1023)));
    push_word(OpRead, '0, '0, 1'b0, 10'd1023, 1);

    while (pending.size() < 1750) begin
      n = pending.size();
      idle_now = (n < 1300) ? 0 : (n < 1550) ? 55 : 16;
      add_spectrum(($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1),
                   ($urandom_range(9) == 0) ? 32'hC0000000 + $urandom_range(1 << 20)
                                            : $urandom_range(1 << 30),
                   ($urandom_range(1) == 1) ? 16 : (1 << 24), $urandom_range(8));
      if ($urandom_range(9) == 0) pending[pending.size() - 1].drain = 1;
    end

    repeat (5) @(posedge clk_i);
    rst_ni = 1'b1;
    while (pending.size() > 0 || start || answers.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d loads, %0d reads, %0d finished spectra.", n_loads, n_reads, n_spectra);
    $display("Status counts: ok %0d, order %0d, full %0d, bad read %0d.",
             stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3]);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
